// ===== src/lpfr_pkg.sv =====
// types and constants shared by the length-prefixed frame receiver
`timescale 1ns / 1ps

package lpfr_pkg;

	// buffer position of the second length byte
	localparam logic [7:0] LENGTH_END_INDEX = 8'd3;
	// hard ceiling on the length limit so positions fit in 8 bits
	localparam logic [7:0] LIMIT_CEILING = 8'd250;

	// configuration register indexes
	localparam logic [1:0] CFG_FIRST_HEADER  = 2'd0;
	localparam logic [1:0] CFG_SECOND_HEADER = 2'd1;
	localparam logic [1:0] CFG_MAX_LENGTH    = 2'd2;

	// receiver phase, one-hot
	typedef enum logic [4:0] {
		PH_HEAD1 = 5'b00001,
		PH_HEAD2 = 5'b00010,
		PH_LEN   = 5'b00100,
		PH_DATA  = 5'b01000,
		PH_CHECK = 5'b10000
	} phase_t;

endpackage

// ===== src/length_prefixed_frame_receiver.sv =====
// length-prefixed frame receiver: header hunt, length, payload and check byte tracking
`timescale 1ns / 1ps

// Usage
//   Input channel (in_valid / in_ready / rx_byte) carries one received byte per beat.
//   Output channel (out_valid / out_ready) carries one result beat per input beat:
//   store_valid, store_index and store_byte for a kept byte, frame_done and
//   frame_bytes on the last check byte of a complete frame.
//   Configuration: cfg_we with cfg_index selects first header byte (0), second
//   header byte (1) or payload length limit (2); index 3 is ignored. Write only
//   while the block is idle.
//   Path: a byte accepted into the input register is decided from there into the
//   result register, which drives out_valid. Throughput is one byte per cycle
//   while out_ready is high, or while the result register is empty.
//   Stall: when out_ready is low the result register holds; the input stage still
//   takes one more byte, then in_ready drops until the result is taken.
//   Reset: phase returns to the header hunt, counters clear, headers reset to 0 and
//   the limit to 250; both stages come up empty.
module length_prefixed_frame_receiver
	import lpfr_pkg::*;
#(
	parameter int CHECK_BYTES = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       store_valid,
	output logic [7:0] store_index,
	output logic [7:0] store_byte,
	output logic       frame_done,
	output logic [8:0] frame_bytes
);

	localparam int CW = (CHECK_BYTES < 2) ? 1 : $clog2(CHECK_BYTES + 1);
	localparam logic [CW-1:0] CHECK_LAST = CW'(CHECK_BYTES);

	// configuration registers
	logic [7:0] first_hdr_q;
	logic [7:0] second_hdr_q;
	logic [7:0] max_len_q;

	// receiver state
	phase_t        phase_q, phase_d;
	logic [7:0]    idx_q, idx_d;
	logic [15:0]   remain_q, remain_d;
	logic [CW-1:0] chk_q, chk_d;

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;

	// result stage
	logic       valid_s2;
	logic       keep_s2;
	logic [7:0] index_s2;
	logic [7:0] data_s2;
	logic       done_s2;
	logic [8:0] total_s2;

	logic       advance;
	logic       keep_d;
	logic       done_d;
	logic [8:0] total_d;
	logic [7:0] limit;
	logic [15:0] remain_shift;
	logic [7:0]  idx_inc;
	logic [15:0] remain_dec;

	// handshake: result stage frees when empty or taken
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || !valid_s2 || out_ready;

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_hdr_q  <= '0;
			second_hdr_q <= '0;
			max_len_q    <= LIMIT_CEILING;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FIRST_HEADER:  first_hdr_q  <= cfg_data;
				CFG_SECOND_HEADER: second_hdr_q <= cfg_data;
				CFG_MAX_LENGTH:    max_len_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	// clamp the limit and precompute small arithmetic
	assign limit        = (max_len_q > LIMIT_CEILING) ? LIMIT_CEILING : max_len_q;
	assign remain_shift = {remain_q[7:0], byte_s1};
	assign idx_inc      = idx_q + 8'd1;
	assign remain_dec   = remain_q - 16'd1;

	// per-byte decision
	always_comb begin
		phase_d  = phase_q;
		idx_d    = idx_q;
		remain_d = remain_q;
		chk_d    = chk_q;
		keep_d   = 1'b0;
		done_d   = 1'b0;
		total_d  = '0;
		unique case (phase_q)
			PH_HEAD1: begin
				if (byte_s1 == first_hdr_q) begin
					idx_d   = '0;
					keep_d  = 1'b1;
					phase_d = PH_HEAD2;
				end
			end
			PH_HEAD2: begin
				if (byte_s1 == second_hdr_q) begin
					idx_d   = idx_inc;
					keep_d  = 1'b1;
					phase_d = PH_LEN;
				end else begin
					phase_d = PH_HEAD1;
				end
			end
			PH_LEN: begin
				idx_d    = idx_inc;
				keep_d   = 1'b1;
				remain_d = remain_shift;
				if (idx_inc == LENGTH_END_INDEX) begin
					phase_d = (remain_shift > {8'd0, limit}) ? PH_HEAD1 : PH_DATA;
				end
			end
			PH_DATA: begin
				if (remain_q != '0) begin
					idx_d    = idx_inc;
					keep_d   = 1'b1;
					remain_d = remain_dec;
				end
				// zero left after this byte (or already zero): move to check bytes
				if (remain_q == '0 || remain_q == 16'd1) begin
					phase_d = PH_CHECK;
					chk_d   = '0;
				end
			end
			PH_CHECK: begin
				idx_d  = idx_inc;
				keep_d = 1'b1;
				chk_d  = chk_q + CW'(1);
				if (chk_q + CW'(1) == CHECK_LAST) begin
					done_d  = 1'b1;
					total_d = {1'b0, idx_inc} + 9'd1;
					phase_d = PH_HEAD1;
					chk_d   = '0;
				end
			end
			default: begin
				phase_d = PH_HEAD1;
			end
		endcase
	end

	// state update on each decided byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HEAD1;
			idx_q    <= '0;
			remain_q <= '0;
			chk_q    <= '0;
		end else if (advance) begin
			phase_q  <= phase_d;
			idx_q    <= idx_d;
			remain_q <= remain_d;
			chk_q    <= chk_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || out_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			keep_s2  <= keep_d;
			index_s2 <= keep_d ? idx_d : 8'd0;
			data_s2  <= keep_d ? byte_s1 : 8'd0;
			done_s2  <= done_d;
			total_s2 <= total_d;
		end
	end

	assign out_valid   = valid_s2;
	assign store_valid = keep_s2;
	assign store_index = index_s2;
	assign store_byte  = data_s2;
	assign frame_done  = done_s2;
	assign frame_bytes = total_s2;

	// a finished frame's count is one past the last stored position
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && done_s2) |-> (keep_s2 && total_s2 == {1'b0, index_s2} + 9'd1))
		else $error("frame_done without matching store or byte count");

	// byte count only appears on frame_done
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !done_s2) |-> (total_s2 == 9'd0))
		else $error("frame_bytes nonzero without frame_done");

	// input stalls only when both stages are full and the result is held
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && valid_s2 && !out_ready))
		else $error("input stalled with room in the pipeline");

	// state moves only when a byte is decided
	assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(phase_q) && $stable(idx_q))
		else $error("receiver state changed without a decided byte");

endmodule
